// ===== design/i2cm_pkg.sv =====
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

  localparam int unsigned QP_W      = 16;
  localparam logic [15:0] QP_RESET  = 16'd100;
  localparam logic [3:0]  BYTE_BITS = 4'd8;

  typedef enum logic [2:0] {
    FN_NONE  = 3'd0,
    FN_START = 3'd1,
    FN_WRITE = 3'd2,
    FN_READ  = 3'd3,
    FN_STOP  = 3'd4
  } func_t;

  typedef enum logic [14:0] {
    PH_IDLE  = 15'b000000000000001,
    PH_S1    = 15'b000000000000010,
    PH_S2    = 15'b000000000000100,
    PH_S3    = 15'b000000000001000,
    PH_WSET  = 15'b000000000010000,
    PH_WRISE = 15'b000000000100000,
    PH_WHIGH = 15'b000000001000000,
    PH_WLOW  = 15'b000000010000000,
    PH_RSET  = 15'b000000100000000,
    PH_RRISE = 15'b000001000000000,
    PH_RHIGH = 15'b000010000000000,
    PH_RLOW  = 15'b000100000000000,
    PH_PA    = 15'b001000000000000,
    PH_PRISE = 15'b010000000000000,
    PH_PC    = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       rd_ack;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       last_bit;
    logic [7:0] read_data;
  } out_item_t;

  // handoff from the engine to the result buffer
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_push_t;

endpackage

// ===== design/i2cm_if.sv =====
// valid/ready channel interfaces for input and result items
interface i2cm_in_if import i2cm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/i2cm_core.sv =====
// input register, divider and bus sequencer, one item per cycle while the result buffer has room
module i2cm_core import i2cm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [QP_W-1:0]  cfg_wdata,
  input  logic             res_room,
  output res_push_t        res_out
);

  logic            in_vld_r;
  in_item_t        in_item_r;
  logic [QP_W-1:0] qp_r;
  phase_t          phase_r, phase_nxt;
  logic [3:0]      bit_cnt_r, bit_cnt_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [QP_W-1:0] div_r, div_nxt;
  logic            div_run_r, div_run_nxt;
  logic            scl_low_r, scl_low_nxt;
  logic            sda_low_r, sda_low_nxt;
  logic            last_bit_r, last_bit_nxt;
  logic            ack_r, ack_nxt;
  logic [7:0]      rd_byte_r, rd_byte_nxt;
  logic            wake;
  logic            done;
  logic            adv;
  logic [3:0]      bc_inc;

  assign adv      = in_vld_r && res_room;
  assign in_ready = !in_vld_r || res_room;
  assign bc_inc   = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    div_nxt      = div_r;
    div_run_nxt  = div_run_r;
    scl_low_nxt  = scl_low_r;
    sda_low_nxt  = sda_low_r;
    last_bit_nxt = last_bit_r;
    ack_nxt      = ack_r;
    rd_byte_nxt  = rd_byte_r;
    wake         = 1'b0;
    done         = 1'b0;

    if (div_run_r) begin
      wake    = (div_r == qp_r);
      div_nxt = wake ? '0 : div_r + 1'b1;
    end

    if (phase_r == PH_IDLE) begin
      priority if (in_item_r.func == FN_START) begin
        div_nxt     = '0;
        div_run_nxt = 1'b1;
        sda_low_nxt = 1'b0;
        phase_nxt   = PH_S1;
      end else if (in_item_r.func == FN_WRITE && div_run_r) begin
        shift_nxt   = in_item_r.data_byte;
        bit_cnt_nxt = '0;
        sda_low_nxt = !in_item_r.data_byte[7];
        phase_nxt   = PH_WSET;
      end else if (in_item_r.func == FN_READ && div_run_r) begin
        shift_nxt   = '0;
        bit_cnt_nxt = '0;
        ack_nxt     = in_item_r.rd_ack;
        phase_nxt   = PH_RSET;
      end else if (in_item_r.func == FN_STOP && div_run_r) begin
        sda_low_nxt = 1'b1;
        phase_nxt   = PH_PA;
      end else begin
        // no command, unknown code, or divider halted
        phase_nxt = PH_IDLE;
      end
    end else if (wake) begin
      unique case (phase_r)
        PH_S1: begin
          sda_low_nxt = 1'b1;
          phase_nxt   = PH_S2;
        end
        PH_S2: begin
          scl_low_nxt = 1'b1;
          phase_nxt   = PH_S3;
        end
        PH_S3: begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_WSET: begin
          scl_low_nxt = 1'b0;
          phase_nxt   = PH_WRISE;
        end
        PH_WRISE: begin
          // wait out clock stretching
          if (in_item_r.scl_in) phase_nxt = PH_WHIGH;
        end
        PH_WHIGH: begin
          last_bit_nxt = in_item_r.sda_in;
          scl_low_nxt  = 1'b1;
          phase_nxt    = PH_WLOW;
        end
        PH_WLOW: begin
          bit_cnt_nxt = bc_inc;
          if (bc_inc < BYTE_BITS) begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            sda_low_nxt = !shift_r[6];
            phase_nxt   = PH_WSET;
          end else if (bc_inc == BYTE_BITS) begin
            // release sda for the ack bit
            sda_low_nxt = 1'b0;
            phase_nxt   = PH_WSET;
          end else begin
            bit_cnt_nxt = '0;
            done        = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        end
        PH_RSET: begin
          if (bit_cnt_r >= BYTE_BITS && ack_r) sda_low_nxt = 1'b1;
          scl_low_nxt = 1'b0;
          phase_nxt   = PH_RRISE;
        end
        PH_RRISE: begin
          if (in_item_r.scl_in) phase_nxt = PH_RHIGH;
        end
        PH_RHIGH: begin
          last_bit_nxt = in_item_r.sda_in;
          scl_low_nxt  = 1'b1;
          phase_nxt    = PH_RLOW;
        end
        PH_RLOW: begin
          if (bit_cnt_r < BYTE_BITS) begin
            shift_nxt   = {shift_r[6:0], last_bit_r};
            bit_cnt_nxt = bc_inc;
            phase_nxt   = PH_RSET;
          end else begin
            sda_low_nxt = 1'b0;
            rd_byte_nxt = shift_r;
            bit_cnt_nxt = '0;
            done        = 1'b1;
            phase_nxt   = PH_IDLE;
          end
        end
        PH_PA: begin
          scl_low_nxt = 1'b0;
          phase_nxt   = PH_PRISE;
        end
        PH_PRISE: begin
          if (in_item_r.scl_in) begin
            sda_low_nxt = 1'b0;
            phase_nxt   = PH_PC;
          end
        end
        PH_PC: begin
          div_run_nxt = 1'b0;
          done        = 1'b1;
          phase_nxt   = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res_out.push               = adv;
    res_out.item.scl_drive_low = scl_low_nxt;
    res_out.item.sda_drive_low = sda_low_nxt;
    res_out.item.busy_res      = (phase_nxt != PH_IDLE);
    res_out.item.done_res      = done;
    res_out.item.last_bit      = last_bit_nxt;
    res_out.item.read_data     = rd_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r <= QP_RESET;
    end else if (cfg_we) begin
      qp_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      div_r      <= '0;
      div_run_r  <= 1'b0;
      scl_low_r  <= 1'b0;
      sda_low_r  <= 1'b0;
      last_bit_r <= 1'b0;
      ack_r      <= 1'b0;
      rd_byte_r  <= '0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      div_r      <= div_nxt;
      div_run_r  <= div_run_nxt;
      scl_low_r  <= scl_low_nxt;
      sda_low_r  <= sda_low_nxt;
      last_bit_r <= last_bit_nxt;
      ack_r      <= ack_nxt;
      rd_byte_r  <= rd_byte_nxt;
    end
  end

endmodule

// ===== design/i2cm_out_buf.sv =====
// two-entry result buffer, keeps the engine running while the sink stalls until both entries fill
module i2cm_out_buf import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_push_t  res_in,
  output logic       res_room,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic [1:0] cnt_r, cnt_nxt;
  out_item_t  ent0_r, ent1_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = ent0_r;
  assign res_room  = (cnt_r != 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_in.push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!res_in.push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // head leaves, second entry or new item moves up
      if (cnt_r == 2'd2) ent0_r <= ent1_r;
      else if (res_in.push) ent0_r <= res_in.item;
      if (res_in.push && cnt_r == 2'd2) ent1_r <= res_in.item;
    end else if (res_in.push) begin
      if (cnt_r == 2'd0) ent0_r <= res_in.item;
      else ent1_r <= res_in.item;
    end
  end

endmodule

// ===== design/i2c_master_byte_engine_top.sv =====
// top level of the i2c master byte engine
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        func, data_byte, rd_ack, scl_in, sda_in
//  out_ch   out  valid/ready        scl/sda drive, busy, done, last_bit, read_data
//  cfg      in   cfg_we             cfg_wdata = quarter_period
//
// one item in and one result out per cycle while nothing stalls; each item is one bus-timing tick
// items pass the input register, then the sequencer into the result buffer
// the result buffer holds two results, so in_ch.ready drops only once two wait
// rst_n is synchronous: sequencer idle, divider halted, quarter_period = 100
module i2c_master_byte_engine_top import i2cm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  i2cm_in_if.sink           in_ch,
  i2cm_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [QP_W-1:0]   cfg_wdata
);

  res_push_t res;
  logic      res_room;

  i2cm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_room  (res_room),
    .res_out   (res)
  );

  i2cm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_in    (res),
    .res_room  (res_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
  );

endmodule

// ===== design/i2cm_checker.sv =====
// port-level checks of the i2c master byte engine, bound to the top level
module i2cm_checker import i2cm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done with busy set");

  // input backpressure only comes from results piling up
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // nothing is offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // after a stalled cycle with both sides full, the input waits too
  a_bp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready && in_valid |=> !in_ready)
    else $error("input taken while results still stalled");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for the i2c master byte engine: directed table, random command streams, scoreboard
module tb;
  import i2cm_pkg::*;

  localparam logic [2:0] FN_RSVD_LO = 3'd5;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;
  localparam int         NO_QP      = -1;
  localparam int         TIMEOUT_NS = 20_000_000;

  localparam out_item_t RES_IDLE  = '0;
  localparam out_item_t RES_START = '{scl_drive_low: 1'b0, sda_drive_low: 1'b0, busy_res: 1'b1,
                                      done_res: 1'b0, last_bit: 1'b0, read_data: 8'h00};

  typedef struct {
    logic [2:0] func;
    logic [7:0] data;
    logic       ack;
    logic       scl;
    logic       sda;
    int         reps;    // 0: keep sending items, empty after the first, until the engine is idle
    int         qp;      // quarter period written before the row, NO_QP keeps it
    bit         typed;
    out_item_t  res;
  } stim_row_t;

  // func, data, ack, scl, sda, reps, qp, typed, result
  stim_row_t dir_tab [20] = '{
    '{FN_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_STOP,    8'h00, 1'b0, 1'b1, 1'b1, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_WRITE,   8'hFF, 1'b1, 1'b1, 1'b1, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_READ,    8'h00, 1'b1, 1'b0, 1'b0, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_RSVD_LO, 8'h00, 1'b0, 1'b1, 1'b1, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_RSVD_HI, 8'hFF, 1'b1, 1'b1, 1'b1, 1,  NO_QP, 1'b1, RES_IDLE},
    '{FN_START,   8'h00, 1'b0, 1'b1, 1'b1, 1,  0,     1'b1, RES_START},
    '{FN_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 3,  NO_QP, 1'b0, RES_IDLE},
    '{FN_WRITE,   8'h00, 1'b0, 1'b1, 1'b0, 40, NO_QP, 1'b0, RES_IDLE},
    '{FN_WRITE,   8'hFF, 1'b0, 1'b1, 1'b1, 40, NO_QP, 1'b0, RES_IDLE},
    // slave stretches the clock during a write
    '{FN_WRITE,   8'hA5, 1'b0, 1'b0, 1'b0, 12, NO_QP, 1'b0, RES_IDLE},
    '{FN_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 40, NO_QP, 1'b0, RES_IDLE},
    '{FN_READ,    8'h00, 1'b1, 1'b1, 1'b1, 40, NO_QP, 1'b0, RES_IDLE},
    '{FN_READ,    8'hFF, 1'b0, 1'b1, 1'b0, 40, NO_QP, 1'b0, RES_IDLE},
    // repeated start while the divider runs
    '{FN_START,   8'h00, 1'b0, 1'b1, 1'b1, 4,  NO_QP, 1'b0, RES_IDLE},
    '{FN_STOP,    8'h00, 1'b0, 1'b0, 1'b1, 6,  NO_QP, 1'b0, RES_IDLE},
    '{FN_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 6,  NO_QP, 1'b0, RES_IDLE},
    '{FN_WRITE,   8'h5A, 1'b0, 1'b1, 1'b1, 2,  NO_QP, 1'b0, RES_IDLE},
    '{FN_START,   8'h00, 1'b0, 1'b1, 1'b1, 3,  65535, 1'b0, RES_IDLE},
    // compare value lowered below the divider, no wake until it wraps
    '{FN_NONE,    8'h00, 1'b0, 1'b1, 1'b1, 8,  1,     1'b0, RES_IDLE}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_byte_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // engine model state
  phase_t      eng_phase;
  logic [3:0]  eng_bits;
  logic [7:0]  eng_shift;
  logic [15:0] eng_div;
  logic        eng_div_on;
  logic        eng_scl_lo;
  logic        eng_sda_lo;
  logic        eng_last;
  logic        eng_ack;
  logic [7:0]  eng_rbyte;
  logic [15:0] eng_qp;

  out_item_t exp_res_q [$];
  int        errors;
  bit        in_took;
  bit        row_typed;
  out_item_t row_res;
  int        tx_idle_pct;
  int        rx_idle_pct;
  bit        hold_req;
  int        hold_left;

  function automatic void reset_engine();
    eng_phase  = PH_IDLE;
    eng_bits   = '0;
    eng_shift  = '0;
    eng_div    = '0;
    eng_div_on = 1'b0;
    eng_scl_lo = 1'b0;
    eng_sda_lo = 1'b0;
    eng_last   = 1'b0;
    eng_ack    = 1'b0;
    eng_rbyte  = '0;
    eng_qp     = QP_RESET;
  endfunction

  // one clock tick of the engine
  function automatic out_item_t step_engine(in_item_t it);
    logic      wake;
    logic      done;
    out_item_t r;
    wake = 1'b0;
    done = 1'b0;
    if (eng_div_on) begin
      wake    = (eng_div == eng_qp);
      eng_div = wake ? 16'd0 : eng_div + 16'd1;
    end
    if (eng_phase == PH_IDLE) begin
      case (it.func)
        FN_START: begin
          eng_div    = '0;
          eng_div_on = 1'b1;
          eng_sda_lo = 1'b0;
          eng_phase  = PH_S1;
        end
        FN_WRITE: if (eng_div_on) begin
          eng_shift  = it.data_byte;
          eng_bits   = '0;
          eng_sda_lo = !eng_shift[7];
          eng_phase  = PH_WSET;
        end
        FN_READ: if (eng_div_on) begin
          eng_shift = '0;
          eng_bits  = '0;
          eng_ack   = it.rd_ack;
          eng_phase = PH_RSET;
        end
        FN_STOP: if (eng_div_on) begin
          eng_sda_lo = 1'b1;
          eng_phase  = PH_PA;
        end
        default: ;
      endcase
    end else if (wake) begin
      case (eng_phase)
        PH_S1: begin eng_sda_lo = 1'b1; eng_phase = PH_S2; end
        PH_S2: begin eng_scl_lo = 1'b1; eng_phase = PH_S3; end
        PH_S3: begin done = 1'b1; eng_phase = PH_IDLE; end
        PH_WSET: begin eng_scl_lo = 1'b0; eng_phase = PH_WRISE; end
        PH_WRISE: if (it.scl_in) eng_phase = PH_WHIGH;
        PH_WHIGH: begin
          eng_last   = it.sda_in;
          eng_scl_lo = 1'b1;
          eng_phase  = PH_WLOW;
        end
        PH_WLOW: begin
          eng_bits = eng_bits + 4'd1;
          if (eng_bits < BYTE_BITS) begin
            eng_shift  = eng_shift << 1;
            eng_sda_lo = !eng_shift[7];
            eng_phase  = PH_WSET;
          end else if (eng_bits == BYTE_BITS) begin
            // release sda for the slave ack
            eng_sda_lo = 1'b0;
            eng_phase  = PH_WSET;
          end else begin
            eng_bits  = '0;
            done      = 1'b1;
            eng_phase = PH_IDLE;
          end
        end
        PH_RSET: begin
          if (eng_bits >= BYTE_BITS && eng_ack) eng_sda_lo = 1'b1;
          eng_scl_lo = 1'b0;
          eng_phase  = PH_RRISE;
        end
        PH_RRISE: if (it.scl_in) eng_phase = PH_RHIGH;
        PH_RHIGH: begin
          eng_last   = it.sda_in;
          eng_scl_lo = 1'b1;
          eng_phase  = PH_RLOW;
        end
        PH_RLOW: begin
          if (eng_bits < BYTE_BITS) begin
            eng_shift = {eng_shift[6:0], eng_last};
            eng_bits  = eng_bits + 4'd1;
            eng_phase = PH_RSET;
          end else begin
            eng_sda_lo = 1'b0;
            eng_rbyte  = eng_shift;
            eng_bits   = '0;
            done       = 1'b1;
            eng_phase  = PH_IDLE;
          end
        end
        PH_PA: begin eng_scl_lo = 1'b0; eng_phase = PH_PRISE; end
        PH_PRISE: if (it.scl_in) begin
          eng_sda_lo = 1'b0;
          eng_phase  = PH_PC;
        end
        PH_PC: begin eng_div_on = 1'b0; done = 1'b1; eng_phase = PH_IDLE; end
        default: eng_phase = PH_IDLE;
      endcase
    end
    r.scl_drive_low = eng_scl_lo;
    r.sda_drive_low = eng_sda_lo;
    r.busy_res      = (eng_phase != PH_IDLE);
    r.done_res      = done;
    r.last_bit      = eng_last;
    r.read_data     = eng_rbyte;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // mostly well-formed command streams, some random noise on func
  function automatic in_item_t gen_item();
    in_item_t it;
    int       r;
    it.data_byte = 8'($urandom);
    it.rd_ack    = 1'($urandom_range(0, 1));
    it.scl_in    = ($urandom_range(0, 9) != 0);
    it.sda_in    = 1'($urandom_range(0, 1));
    it.func      = FN_NONE;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.func = 3'($urandom_range(0, 7));
    end else if (eng_phase == PH_IDLE && r < 60) begin
      if (!eng_div_on) begin
        it.func = FN_START;
      end else begin
        r = $urandom_range(0, 19);
        it.func = (r < 8) ? FN_WRITE : (r < 15) ? FN_READ : (r < 18) ? FN_STOP : FN_START;
      end
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    row_typed = typed;
    row_res   = res;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (exp_res_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_qp(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Some tests failed");
    $finish;
  end

  // scoreboard: results are checked before the item of the same edge is predicted
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      reset_engine();
      exp_res_q.delete();
      in_took = 1'b0;
    end else begin
      if (cfg_we) eng_qp = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (exp_res_q.size() == 0) begin
          $error("result item with no expected item pending");
          errors++;
        end else begin
          want = exp_res_q.pop_front();
          check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(got.scl_drive_low));
          check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(got.sda_drive_low));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("last_bit", 8'(want.last_bit), 8'(got.last_bit));
          check_field("read_data", want.read_data, got.read_data);
        end
      end
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        want = step_engine(in_ch.data);
        exp_res_q.push_back(row_typed ? row_res : want);
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [15:0] qp;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    errors      = 0;
    row_typed   = 1'b0;
    row_res     = '0;
    hold_req    = 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 69;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].qp != NO_QP) begin
        drain_results();
        write_qp(dir_tab[r].qp[15:0]);
      end
      for (int k = 0; (dir_tab[r].reps == 0) ? (eng_phase != PH_IDLE) : (k < dir_tab[r].reps);
           k++) begin
        it.func      = (k == 0) ? dir_tab[r].func : FN_NONE;
        it.data_byte = dir_tab[r].data;
        it.rd_ack    = dir_tab[r].ack;
        it.scl_in    = dir_tab[r].scl;
        it.sda_in    = dir_tab[r].sda;
        send_item(it, dir_tab[r].typed, dir_tab[r].res);
      end
    end

    for (int g = 0; g < 3; g++) begin
      case (g)
        0: begin tx_idle_pct = 28; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 28; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int p = 0; p < 4; p++) begin
        drain_results();
        qp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 9)) : 16'($urandom_range(0, 3));
        // never drop below a running divider, that would take a full wrap
        if (eng_div_on && qp < eng_div) qp = eng_div;
        write_qp(qp);
        for (int n = 0; n < 80; n++) begin
          if (p == 0 && n == 30) hold_req = 1'b1;
          send_item(gen_item(), 1'b0, RES_IDLE);
        end
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (errors == 0 && exp_res_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_core.sv
design/i2cm_out_buf.sv
design/i2c_master_byte_engine_top.sv
design/i2cm_checker.sv
dv/tb.sv
